// ===== rtl/cpu8_pkg.sv =====
// Package with the opcodes, flag positions and decode table of the 8-bit execute unit.
package cpu8_pkg;

  // Bit positions in the status byte.
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  localparam logic [7:0] ResetAcc   = 8'h00;
  localparam logic [7:0] ResetIndex = 8'h00;
  localparam logic [7:0] ResetSp    = 8'hFF;
  localparam logic [7:0] ResetFlags = 8'h24;

  localparam logic [3:0] BcdDigitMax = 4'h9;
  localparam logic [3:0] BcdAdjust   = 4'h6;

  typedef enum logic [1:0] {
    OUTCOME_EXEC        = 2'd0,
    OUTCOME_ILLEGAL     = 2'd1,
    OUTCOME_UNSUPPORTED = 2'd2
  } outcome_e;

  // Accumulator group, selected by opcode bits 7:5 when bits 1:0 are 01.
  typedef enum logic [2:0] {
    GRP_ORA = 3'd0,
    GRP_AND = 3'd1,
    GRP_EOR = 3'd2,
    GRP_ADC = 3'd3,
    GRP_STA = 3'd4,
    GRP_LDA = 3'd5,
    GRP_CMP = 3'd6,
    GRP_SBC = 3'd7
  } alu_grp_e;

  localparam logic [1:0] AluGroupSel = 2'b01;

  localparam logic [7:0] OpLdxImm  = 8'hA2;
  localparam logic [7:0] OpLdxZp   = 8'hA6;
  localparam logic [7:0] OpLdxZpy  = 8'hB6;
  localparam logic [7:0] OpLdxAbs  = 8'hAE;
  localparam logic [7:0] OpLdxAbsy = 8'hBE;
  localparam logic [7:0] OpLdyImm  = 8'hA0;
  localparam logic [7:0] OpLdyZp   = 8'hA4;
  localparam logic [7:0] OpLdyZpx  = 8'hB4;
  localparam logic [7:0] OpLdyAbs  = 8'hAC;
  localparam logic [7:0] OpLdyAbsx = 8'hBC;
  localparam logic [7:0] OpCpxImm  = 8'hE0;
  localparam logic [7:0] OpCpxZp   = 8'hE4;
  localparam logic [7:0] OpCpxAbs  = 8'hEC;
  localparam logic [7:0] OpCpyImm  = 8'hC0;
  localparam logic [7:0] OpCpyZp   = 8'hC4;
  localparam logic [7:0] OpCpyAbs  = 8'hCC;
  localparam logic [7:0] OpInx     = 8'hE8;
  localparam logic [7:0] OpDex     = 8'hCA;
  localparam logic [7:0] OpIny     = 8'hC8;
  localparam logic [7:0] OpDey     = 8'h88;
  localparam logic [7:0] OpTax     = 8'hAA;
  localparam logic [7:0] OpTay     = 8'hA8;
  localparam logic [7:0] OpTxa     = 8'h8A;
  localparam logic [7:0] OpTya     = 8'h98;
  localparam logic [7:0] OpTsx     = 8'hBA;
  localparam logic [7:0] OpTxs     = 8'h9A;
  localparam logic [7:0] OpClc     = 8'h18;
  localparam logic [7:0] OpSec     = 8'h38;
  localparam logic [7:0] OpCli     = 8'h58;
  localparam logic [7:0] OpSei     = 8'h78;
  localparam logic [7:0] OpClv     = 8'hB8;
  localparam logic [7:0] OpCld     = 8'hD8;
  localparam logic [7:0] OpSed     = 8'hF8;
  localparam logic [7:0] OpNop     = 8'hEA;
  localparam logic [7:0] OpBpl     = 8'h10;
  localparam logic [7:0] OpBmi     = 8'h30;
  localparam logic [7:0] OpBvc     = 8'h50;
  localparam logic [7:0] OpBvs     = 8'h70;
  localparam logic [7:0] OpBcc     = 8'h90;
  localparam logic [7:0] OpBcs     = 8'hB0;
  localparam logic [7:0] OpBne     = 8'hD0;
  localparam logic [7:0] OpBeq     = 8'hF0;

  // Bit n of row r is set when opcode {r, n} is a documented opcode.
  localparam logic [15:0] DocRows [16] = '{
    16'h6763, 16'h6363, 16'h7773, 16'h6363, 16'h7763, 16'h6363, 16'h7763, 16'h6363,
    16'h7572, 16'h2773, 16'h7777, 16'h7773, 16'h7773, 16'h6363, 16'h7773, 16'h6363
  };

  function automatic logic is_documented(logic [7:0] op);
    logic [15:0] row;
    row = DocRows[op[7:4]];
    return row[op[3:0]];
  endfunction

endpackage

// ===== rtl/cpu_8bit_execute_unit.sv =====
// Execute unit of an 8-bit CPU: registers, flags, ALU and branch tests, one word per cycle
// while the output side is ready. An accepted word waits in the input stage and executes
// as it moves into the result stage, whose result word is shown from then on.
// Throughput: one word per cycle when the output is ready; an input stage and a result
// stage let a new word be taken while a finished result still waits downstream.
// Reset: A, X and Y clear, the stack pointer goes to 0xFF and the status byte to 0x24.
module cpu_8bit_execute_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] req_type_i,
  input  logic [7:0] operand_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] acc_out_o,
  output logic [7:0] x_out_o,
  output logic [7:0] y_out_o,
  output logic [7:0] flags_out_o,
  output logic       branch_taken_o,
  output logic [1:0] outcome_o
);
  import cpu8_pkg::*;

  // Input stage. It holds one word until the result stage can take its result.
  logic       in_valid_q;
  logic [7:0] op_q;
  logic [7:0] opnd_q;

  // Architectural state, updated when a word moves from the input stage into the
  // result stage, so the words execute strictly in order.
  logic [7:0] acc_q, acc_d;
  logic [7:0] x_q, x_d;
  logic [7:0] y_q, y_d;
  logic [7:0] sp_q, sp_d;
  logic [7:0] flags_q, flags_d;

  // Result stage.
  logic     out_valid_q;
  logic     taken_q, taken_d;
  outcome_e outcome_q, outcome_d;
  logic [7:0] acc_out_q, x_out_q, y_out_q, flags_out_q;

  logic advance;
  logic in_accept;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  // Add with carry, binary and decimal. The decimal form adjusts each digit by six
  // when it passes nine; the high digit takes the decimal carry of the low one.
  logic       cin;
  logic [8:0] adc_bin;
  logic [4:0] adc_lo;
  logic [4:0] adc_lo_adj;
  logic       adc_lo_gt9;
  logic [4:0] adc_hi;
  logic [5:0] adc_hi_adj;
  logic [7:0] adc_res;
  logic       adc_c;
  logic       adc_v;

  assign cin        = flags_q[FlagC];
  assign adc_bin    = {1'b0, acc_q} + {1'b0, opnd_q} + {8'd0, cin};
  assign adc_lo     = {1'b0, acc_q[3:0]} + {1'b0, opnd_q[3:0]} + {4'd0, cin};
  assign adc_lo_gt9 = adc_lo > {1'b0, BcdDigitMax};
  assign adc_lo_adj = adc_lo_gt9 ? adc_lo + {1'b0, BcdAdjust} : adc_lo;
  assign adc_hi     = {1'b0, acc_q[7:4]} + {1'b0, opnd_q[7:4]} + {4'd0, adc_lo_gt9};
  assign adc_hi_adj = (adc_hi > {1'b0, BcdDigitMax}) ? {1'b0, adc_hi} + {2'd0, BcdAdjust}
                                                     : {1'b0, adc_hi};

  always_comb begin
    if (flags_q[FlagD]) begin
      adc_res = {adc_hi_adj[3:0], adc_lo_adj[3:0]};
      adc_c   = adc_hi_adj[5:4] != 2'd0;
    end else begin
      adc_res = adc_bin[7:0];
      adc_c   = adc_bin[8];
    end
  end

  assign adc_v = (acc_q[7] == opnd_q[7]) && (acc_q[7] != adc_res[7]);

  // Subtract with borrow. In decimal mode a low digit borrow takes six off the low
  // digit and one off the high digit; a high digit borrow takes six off the high digit.
  // In decimal mode the borrow out is bit 4 of the adjusted high digit.
  logic       bin;
  logic [8:0] sbc_bin;
  logic [4:0] sbc_lo, sbc_lo_adj;
  logic [4:0] sbc_hi, sbc_hi_mid, sbc_hi_adj;
  logic [8:0] sbc_res;
  logic       sbc_v;

  assign bin        = !cin;
  assign sbc_bin    = {1'b0, acc_q} - {1'b0, opnd_q} - {8'd0, bin};
  assign sbc_lo     = {1'b0, acc_q[3:0]} - {1'b0, opnd_q[3:0]} - {4'd0, bin};
  assign sbc_hi     = {1'b0, acc_q[7:4]} - {1'b0, opnd_q[7:4]};
  assign sbc_lo_adj = sbc_lo[4] ? sbc_lo - {1'b0, BcdAdjust} : sbc_lo;
  assign sbc_hi_mid = sbc_lo[4] ? sbc_hi - 5'd1 : sbc_hi;
  assign sbc_hi_adj = sbc_hi_mid[4] ? sbc_hi_mid - {1'b0, BcdAdjust} : sbc_hi_mid;
  assign sbc_res    = flags_q[FlagD] ? {sbc_hi_adj, sbc_lo_adj[3:0]} : sbc_bin;
  assign sbc_v      = (acc_q[7] != opnd_q[7]) && (acc_q[7] != sbc_res[7]);

  // Compares against A, X and Y: carry is "no borrow", Z and N from the difference.
  logic [8:0] cmp_a, cmp_x, cmp_y;
  assign cmp_a = {1'b0, acc_q} - {1'b0, opnd_q};
  assign cmp_x = {1'b0, x_q} - {1'b0, opnd_q};
  assign cmp_y = {1'b0, y_q} - {1'b0, opnd_q};

  // Execute one word. Any result that sets Z and N goes through zn_val.
  always_comb begin
    logic [7:0] zn_val;
    logic       zn_en;
    acc_d     = acc_q;
    x_d       = x_q;
    y_d       = y_q;
    sp_d      = sp_q;
    flags_d   = flags_q;
    taken_d   = 1'b0;
    outcome_d = OUTCOME_EXEC;
    zn_val    = 8'd0;
    zn_en     = 1'b0;

    if (!is_documented(op_q)) begin
      outcome_d = OUTCOME_ILLEGAL;
    end else if (op_q[1:0] == AluGroupSel && alu_grp_e'(op_q[7:5]) != GRP_STA) begin
      zn_en = 1'b1;
      unique case (alu_grp_e'(op_q[7:5]))
        GRP_ORA: begin
          acc_d  = acc_q | opnd_q;
          zn_val = acc_d;
        end
        GRP_AND: begin
          acc_d  = acc_q & opnd_q;
          zn_val = acc_d;
        end
        GRP_EOR: begin
          acc_d  = acc_q ^ opnd_q;
          zn_val = acc_d;
        end
        GRP_ADC: begin
          acc_d          = adc_res;
          zn_val         = adc_res;
          flags_d[FlagC] = adc_c;
          flags_d[FlagV] = adc_v;
        end
        GRP_LDA: begin
          acc_d  = opnd_q;
          zn_val = opnd_q;
        end
        GRP_CMP: begin
          zn_val         = cmp_a[7:0];
          flags_d[FlagC] = !cmp_a[8];
        end
        GRP_SBC: begin
          acc_d          = sbc_res[7:0];
          zn_val         = sbc_res[7:0];
          flags_d[FlagC] = !sbc_res[8];
          flags_d[FlagV] = sbc_v;
        end
        default: begin
          zn_en = 1'b0;
        end
      endcase
    end else begin
      unique case (op_q)
        OpLdxImm, OpLdxZp, OpLdxZpy, OpLdxAbs, OpLdxAbsy: begin
          x_d    = opnd_q;
          zn_val = opnd_q;
          zn_en  = 1'b1;
        end
        OpLdyImm, OpLdyZp, OpLdyZpx, OpLdyAbs, OpLdyAbsx: begin
          y_d    = opnd_q;
          zn_val = opnd_q;
          zn_en  = 1'b1;
        end
        OpCpxImm, OpCpxZp, OpCpxAbs: begin
          zn_val         = cmp_x[7:0];
          zn_en          = 1'b1;
          flags_d[FlagC] = !cmp_x[8];
        end
        OpCpyImm, OpCpyZp, OpCpyAbs: begin
          zn_val         = cmp_y[7:0];
          zn_en          = 1'b1;
          flags_d[FlagC] = !cmp_y[8];
        end
        OpInx: begin
          x_d    = x_q + 8'd1;
          zn_val = x_d;
          zn_en  = 1'b1;
        end
        OpDex: begin
          x_d    = x_q - 8'd1;
          zn_val = x_d;
          zn_en  = 1'b1;
        end
        OpIny: begin
          y_d    = y_q + 8'd1;
          zn_val = y_d;
          zn_en  = 1'b1;
        end
        OpDey: begin
          y_d    = y_q - 8'd1;
          zn_val = y_d;
          zn_en  = 1'b1;
        end
        OpTax: begin
          x_d    = acc_q;
          zn_val = acc_q;
          zn_en  = 1'b1;
        end
        OpTay: begin
          y_d    = acc_q;
          zn_val = acc_q;
          zn_en  = 1'b1;
        end
        OpTxa: begin
          acc_d  = x_q;
          zn_val = x_q;
          zn_en  = 1'b1;
        end
        OpTya: begin
          acc_d  = y_q;
          zn_val = y_q;
          zn_en  = 1'b1;
        end
        OpTsx: begin
          x_d    = sp_q;
          zn_val = sp_q;
          zn_en  = 1'b1;
        end
        OpTxs:   sp_d           = x_q;
        OpClc:   flags_d[FlagC] = 1'b0;
        OpSec:   flags_d[FlagC] = 1'b1;
        OpCli:   flags_d[FlagI] = 1'b0;
        OpSei:   flags_d[FlagI] = 1'b1;
        OpClv:   flags_d[FlagV] = 1'b0;
        OpCld:   flags_d[FlagD] = 1'b0;
        OpSed:   flags_d[FlagD] = 1'b1;
        OpNop:   ;
        OpBpl:   taken_d = !flags_q[FlagN];
        OpBmi:   taken_d = flags_q[FlagN];
        OpBvc:   taken_d = !flags_q[FlagV];
        OpBvs:   taken_d = flags_q[FlagV];
        OpBcc:   taken_d = !flags_q[FlagC];
        OpBcs:   taken_d = flags_q[FlagC];
        OpBne:   taken_d = !flags_q[FlagZ];
        OpBeq:   taken_d = flags_q[FlagZ];
        default: outcome_d = OUTCOME_UNSUPPORTED;
      endcase
    end

    if (zn_en) begin
      flags_d[FlagZ] = zn_val == 8'd0;
      flags_d[FlagN] = zn_val[7];
    end
  end

  // Input stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= req_type_i;
      opnd_q <= operand_i;
    end
  end

  // Architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= ResetAcc;
      x_q     <= ResetIndex;
      y_q     <= ResetIndex;
      sp_q    <= ResetSp;
      flags_q <= ResetFlags;
    end else if (advance) begin
      acc_q   <= acc_d;
      x_q     <= x_d;
      y_q     <= y_d;
      sp_q    <= sp_d;
      flags_q <= flags_d;
    end
  end

  // Result stage. The result word holds until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      acc_out_q   <= acc_d;
      x_out_q     <= x_d;
      y_out_q     <= y_d;
      flags_out_q <= flags_d;
      taken_q     <= taken_d;
      outcome_q   <= outcome_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign acc_out_o      = acc_out_q;
  assign x_out_o        = x_out_q;
  assign y_out_o        = y_out_q;
  assign flags_out_o    = flags_out_q;
  assign branch_taken_o = taken_q;
  assign outcome_o      = outcome_q;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the 8-bit execute unit, with its own model of the registers and flags.
module tb;
  import cpu8_pkg::*;

  localparam int unsigned IdlePercent = 18;
  localparam int unsigned TailCycles  = 8;
  localparam int unsigned CycleLimit  = 100000;
  localparam int unsigned ErrorsShown = 10;

  // Accumulator group opcodes that the package leaves unnamed.
  localparam logic [7:0] OpOraImm = 8'h09;
  localparam logic [7:0] OpAndImm = 8'h29;
  localparam logic [7:0] OpEorImm = 8'h49;
  localparam logic [7:0] OpAdcImm = 8'h69;
  localparam logic [7:0] OpLdaImm = 8'hA9;
  localparam logic [7:0] OpCmpImm = 8'hC9;
  localparam logic [7:0] OpSbcImm = 8'hE9;
  // A documented store, a documented break, and an opcode with no documented meaning.
  localparam logic [7:0] OpStaZp  = 8'h85;
  localparam logic [7:0] OpBrk    = 8'h00;
  localparam logic [7:0] OpJam    = 8'h02;

  // Bit n of row r is set when opcode {r, n} is documented.
  localparam logic [15:0] DocumentedMap [16] = '{
    16'h6763, 16'h6363, 16'h7773, 16'h6363, 16'h7763, 16'h6363, 16'h7763, 16'h6363,
    16'h7572, 16'h2773, 16'h7777, 16'h7773, 16'h7773, 16'h6363, 16'h7773, 16'h6363
  };

  // Implied, index and branch opcodes that this unit executes.
  localparam logic [7:0] RegisterOps [42] = '{
    OpLdxImm, OpLdxZp, OpLdxZpy, OpLdxAbs, OpLdxAbsy,
    OpLdyImm, OpLdyZp, OpLdyZpx, OpLdyAbs, OpLdyAbsx,
    OpCpxImm, OpCpxZp, OpCpxAbs, OpCpyImm, OpCpyZp, OpCpyAbs,
    OpInx, OpDex, OpIny, OpDey, OpTax, OpTay, OpTxa, OpTya, OpTsx, OpTxs,
    OpClc, OpSec, OpCli, OpSei, OpClv, OpCld, OpSed, OpNop,
    OpBpl, OpBmi, OpBvc, OpBvs, OpBcc, OpBcs, OpBne, OpBeq
  };

  localparam logic [7:0] EdgeOperands [11] = '{
    8'h00, 8'h01, 8'h09, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'h99, 8'hF0, 8'hFE, 8'hFF
  };

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] flags;
    logic       taken;
    outcome_e   outcome;
  } exec_word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] req_type_i;
  logic [7:0] operand_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] acc_out_o;
  logic [7:0] x_out_o;
  logic [7:0] y_out_o;
  logic [7:0] flags_out_o;
  logic       branch_taken_o;
  logic [1:0] outcome_o;

  // Register file of the model, starting from the reset values.
  logic [7:0] reg_a  = ResetAcc;
  logic [7:0] reg_x  = ResetIndex;
  logic [7:0] reg_y  = ResetIndex;
  logic [7:0] reg_sp = ResetSp;
  logic [7:0] reg_p  = ResetFlags;

  exec_word_t  expected_words [$];
  int unsigned fail_count;
  int unsigned words_checked;
  int unsigned tick_total;
  int unsigned stall_request;
  logic        src_idle_on;
  logic        sink_idle_on;

  cpu_8bit_execute_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .operand_i     (operand_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .acc_out_o     (acc_out_o),
    .x_out_o       (x_out_o),
    .y_out_o       (y_out_o),
    .flags_out_o   (flags_out_o),
    .branch_taken_o(branch_taken_o),
    .outcome_o     (outcome_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sets Z and N from a result byte and passes the byte on.
  function automatic logic [7:0] set_zn(logic [7:0] value);
    reg_p[FlagZ] = (value == 8'h00);
    reg_p[FlagN] = value[7];
    return value;
  endfunction

  function automatic void compare_with(logic [7:0] lhs, logic [7:0] rhs);
    reg_p[FlagC] = (lhs >= rhs);
    void'(set_zn(lhs - rhs));
  endfunction

  // Executes one opcode on the model registers and returns the word the unit should show.
  function automatic exec_word_t execute_word(logic [7:0] op, logic [7:0] data);
    exec_word_t w;
    logic [15:0] doc_row;
    alu_grp_e    grp;
    logic        carry;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] res16;
    w.taken   = 1'b0;
    w.outcome = OUTCOME_EXEC;
    doc_row   = DocumentedMap[op[7:4]];
    grp       = alu_grp_e'(op[7:5]);
    if (!doc_row[op[3:0]]) begin
      w.outcome = OUTCOME_ILLEGAL;
    end else if (op[1:0] == AluGroupSel && grp != GRP_STA) begin
      case (grp)
        GRP_ORA: reg_a = set_zn(reg_a | data);
        GRP_AND: reg_a = set_zn(reg_a & data);
        GRP_EOR: reg_a = set_zn(reg_a ^ data);
        GRP_LDA: reg_a = set_zn(data);
        GRP_CMP: compare_with(reg_a, data);
        GRP_ADC: begin
          carry = reg_p[FlagC];
          res16 = {8'h00, reg_a} + {8'h00, data} + carry;
          if (reg_p[FlagD]) begin
            // Decimal add: each digit that passes nine is pushed past the next
            // digit boundary by adding six.
            lo = reg_a[3:0] + data[3:0] + carry;
            hi = reg_a[7:4] + data[7:4] + (lo > BcdDigitMax);
            if (lo > BcdDigitMax) lo = lo + BcdAdjust;
            if (hi > BcdDigitMax) hi = hi + BcdAdjust;
            res16 = {hi[11:0], lo[3:0]};
            reg_p[FlagC] = (hi > 16'h000F);
          end else begin
            reg_p[FlagC] = (res16 > 16'h00FF);
          end
          reg_p[FlagV] = !(reg_a[7] ^ data[7]) && (reg_a[7] ^ res16[7]);
          reg_a = set_zn(res16[7:0]);
        end
        default: begin
          carry = !reg_p[FlagC];
          res16 = {8'h00, reg_a} - {8'h00, data} - carry;
          if (reg_p[FlagD]) begin
            // Decimal subtract: a low digit borrow takes six from the low digit
            // and one from the high digit; a high digit borrow takes six more.
            lo = reg_a[3:0] - data[3:0] - carry;
            hi = reg_a[7:4] - data[7:4];
            if (lo[4]) begin
              lo = lo - BcdAdjust;
              hi = hi - 16'd1;
            end
            if (hi[4]) hi = hi - BcdAdjust;
            res16 = {hi[11:0], lo[3:0]};
          end
          reg_p[FlagC] = !res16[8];
          reg_p[FlagV] = (reg_a[7] ^ data[7]) && (reg_a[7] ^ res16[7]);
          reg_a = set_zn(res16[7:0]);
        end
      endcase
    end else begin
      case (op)
        OpLdxImm, OpLdxZp, OpLdxZpy, OpLdxAbs, OpLdxAbsy: reg_x = set_zn(data);
        OpLdyImm, OpLdyZp, OpLdyZpx, OpLdyAbs, OpLdyAbsx: reg_y = set_zn(data);
        OpCpxImm, OpCpxZp, OpCpxAbs: compare_with(reg_x, data);
        OpCpyImm, OpCpyZp, OpCpyAbs: compare_with(reg_y, data);
        OpInx: reg_x = set_zn(reg_x + 8'd1);
        OpDex: reg_x = set_zn(reg_x - 8'd1);
        OpIny: reg_y = set_zn(reg_y + 8'd1);
        OpDey: reg_y = set_zn(reg_y - 8'd1);
        OpTax: reg_x = set_zn(reg_a);
        OpTay: reg_y = set_zn(reg_a);
        OpTxa: reg_a = set_zn(reg_x);
        OpTya: reg_a = set_zn(reg_y);
        OpTsx: reg_x = set_zn(reg_sp);
        OpTxs: reg_sp = reg_x;
        OpClc: reg_p[FlagC] = 1'b0;
        OpSec: reg_p[FlagC] = 1'b1;
        OpCli: reg_p[FlagI] = 1'b0;
        OpSei: reg_p[FlagI] = 1'b1;
        OpClv: reg_p[FlagV] = 1'b0;
        OpCld: reg_p[FlagD] = 1'b0;
        OpSed: reg_p[FlagD] = 1'b1;
        OpNop: ;
        OpBpl: w.taken = !reg_p[FlagN];
        OpBmi: w.taken = reg_p[FlagN];
        OpBvc: w.taken = !reg_p[FlagV];
        OpBvs: w.taken = reg_p[FlagV];
        OpBcc: w.taken = !reg_p[FlagC];
        OpBcs: w.taken = reg_p[FlagC];
        OpBne: w.taken = !reg_p[FlagZ];
        OpBeq: w.taken = reg_p[FlagZ];
        default: w.outcome = OUTCOME_UNSUPPORTED;
      endcase
    end
    w.acc   = reg_a;
    w.x     = reg_x;
    w.y     = reg_y;
    w.flags = reg_p;
    return w;
  endfunction

  // Mostly accumulator group and register opcodes, the rest any byte at all.
  function automatic logic [7:0] pick_opcode();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) return {3'($urandom_range(7)), 3'($urandom_range(7)), AluGroupSel};
    if (roll < 80) return RegisterOps[$urandom_range($size(RegisterOps) - 1)];
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_operand();
    if ($urandom_range(99) < 30) return EdgeOperands[$urandom_range($size(EdgeOperands) - 1)];
    return 8'($urandom);
  endfunction

  // Offers one word, holds it until the unit takes it, then records what it should return.
  // Called at a rising edge; returns at the edge where the word was accepted.
  task automatic send_word(input logic [7:0] op, input logic [7:0] data);
    while (src_idle_on && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= op;
    operand_i  <= data;
    do @(posedge clk_i); while (!in_ready_o);
    expected_words.push_back(execute_word(op, data));
  endtask

  // Extremes, each kind of operation, decimal carries and borrows, and the two
  // kinds of opcode that the unit does not execute.
  task automatic test_directed_opcodes();
    send_word(OpBpl, 8'h00);      // reset values and a taken branch
    send_word(OpBeq, 8'hFF);      // branch not taken
    send_word(OpLdaImm, 8'h00);
    send_word(OpLdaImm, 8'h7F);
    send_word(OpAdcImm, 8'h01);   // signed overflow into negative
    send_word(OpBvs, 8'h00);
    send_word(OpClv, 8'h00);
    send_word(OpSec, 8'h00);
    send_word(OpSbcImm, 8'hFF);   // borrow out
    send_word(OpOraImm, 8'hFF);
    send_word(OpAndImm, 8'h0F);
    send_word(OpEorImm, 8'hFF);
    send_word(OpSed, 8'h00);
    send_word(OpLdaImm, 8'h99);
    send_word(OpAdcImm, 8'h01);   // decimal carry out of both digits
    send_word(OpSbcImm, 8'h01);   // decimal borrow from the low digit
    send_word(OpSbcImm, 8'h90);   // decimal subtract with no borrow from either digit
    send_word(OpCld, 8'h00);
    send_word(OpCmpImm, 8'h80);
    send_word(OpLdxImm, 8'hFF);
    send_word(OpInx, 8'h00);      // X wraps to zero
    send_word(OpDey, 8'h00);      // Y wraps to 0xFF
    send_word(OpCpyImm, 8'hFF);
    send_word(OpTxs, 8'h00);
    send_word(OpJam, 8'hFF);
    send_word(OpStaZp, 8'h00);
    send_word(OpBrk, 8'h80);
  endtask

  task automatic test_random_mix(input int unsigned count);
    repeat (count) send_word(pick_opcode(), pick_operand());
  endtask

  task automatic test_no_idle_stretch(input int unsigned count);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    test_random_mix(count);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Decimal mode with mostly valid digit pairs and some invalid ones.
  task automatic test_decimal_arith(input int unsigned count);
    logic [7:0]  op;
    logic [7:0]  data;
    int unsigned roll;
    send_word(OpSed, 8'h00);
    repeat (count) begin
      roll = $urandom_range(99);
      if ($urandom_range(99) < 80) data = {4'($urandom_range(9)), 4'($urandom_range(9))};
      else data = 8'($urandom);
      if (roll < 40) op = {GRP_ADC, 3'($urandom_range(7)), AluGroupSel};
      else if (roll < 80) op = {GRP_SBC, 3'($urandom_range(7)), AluGroupSel};
      else if (roll < 88) op = OpLdaImm;
      else if (roll < 94) op = OpSec;
      else op = OpClc;
      send_word(op, data);
    end
    send_word(OpCld, 8'h00);
  endtask

  // The result side holds off long enough for the unit to fill and stall its input.
  task automatic test_output_stall();
    src_idle_on   = 1'b0;
    stall_request = 64;
    test_random_mix(80);
    src_idle_on   = 1'b1;
  endtask

  // Takes result words, checks them in order, and drives out_ready_i.
  initial begin : result_checker
    exec_word_t  want;
    exec_word_t  got;
    int unsigned hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = '{acc: acc_out_o, x: x_out_o, y: y_out_o, flags: flags_out_o,
                taken: branch_taken_o, outcome: outcome_e'(outcome_o)};
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= ErrorsShown)
            $display("result word %0d arrived with none expected", words_checked);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= ErrorsShown) begin
              $display("word %0d: expected a=%h x=%h y=%h p=%h br=%b oc=%0d",
                       words_checked, want.acc, want.x, want.y, want.flags, want.taken,
                       want.outcome);
              $display("word %0d: got      a=%h x=%h y=%h p=%h br=%b oc=%0d",
                       words_checked, got.acc, got.x, got.y, got.flags, got.taken,
                       got.outcome);
            end
          end
        end
        words_checked++;
      end
      if (stall_request != 0) begin
        hold_left     = stall_request;
        stall_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(sink_idle_on && $urandom_range(99) < IdlePercent);
      end
    end
  end

  initial begin : watchdog
    tick_total = 0;
    while (tick_total < CycleLimit) begin
      @(posedge clk_i);
      tick_total++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    req_type_i    = 8'h00;
    operand_i     = 8'h00;
    src_idle_on   = 1'b1;
    sink_idle_on  = 1'b1;
    stall_request = 0;
    fail_count    = 0;
    words_checked = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_opcodes();
    test_random_mix(900);
    test_no_idle_stretch(300);
    test_decimal_arith(400);
    test_output_stall();
    test_random_mix(150);

    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
